FILE: sv/crc32_length_prefixed_deframer_assert.svh
// Assertion macros for the length-prefixed CRC-32 deframer.
// Included by the top level; relies on aclk and aresetn in scope.
`ifndef CRC32_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define CRC32_LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deframer check failed");
`define DFR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("deframer reset check failed");
`else
`define DFR_ASSERT(lbl, prop)
`define DFR_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: sv/crcdfr_pkg.sv
// Types, constants and the bytewise CRC-32 step for the deframer.
// No dependencies.
package crcdfr_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd6;

    typedef enum logic [2:0] {
        PH_HDR_LO  = 3'd0,
        PH_HDR_HI  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC0    = 3'd3,
        PH_CRC1    = 3'd4,
        PH_CRC2    = 3'd5,
        PH_CRC3    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_OK      = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_TRUNC   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         payload_byte;
        logic [COUNT_W-1:0] consumed_count;
        logic               run_last;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = {24'd0, c[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x ^ (c >> 8);
    endfunction

endpackage

FILE: sv/crc32_length_prefixed_deframer.sv
// Deframer for length-prefixed frames with a trailing CRC-32; needs crcdfr_pkg
// and the assertion header. Result beats pass through the registered result
// queue before they appear on the output. Throughput: one input beat per cycle,
// limited by the output side (a truncation after a payload byte adds one result
// beat); a 4-entry result queue decouples the sides. Reset (aresetn low, synchronous)
// empties the queue and returns the frame state to header-low-byte expected.
`include "crc32_length_prefixed_deframer_assert.svh"

module crc32_length_prefixed_deframer
    import crcdfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [24:8] consumed_count, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // run_last
);

    phase_t      phase_reg,  phase_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] cnt_reg,    cnt_next;
    logic [31:0] crc_reg,    crc_next;
    logic [31:0] rcrc_reg,   rcrc_next;

    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;

    logic        accept;
    logic        pop;
    logic [1:0]  push_n;
    result_t     res0, res1;
    logic [15:0] cnt_inc;
    logic [31:0] rcrc_full;
    logic        done;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (fill_reg <= QCNT_W'(QDEPTH - 2));
    assign cnt_inc  = cnt_reg + 16'd1;
    assign rcrc_full = {s_tdata, rcrc_reg[23:0]};

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        push_n     = 2'd0;
        done       = 1'b0;
        res0       = '{kind: KIND_PAYLOAD, payload_byte: 8'd0,
                       consumed_count: '0, run_last: 1'b1};
        res1       = '{kind: KIND_TRUNC, payload_byte: 8'd0,
                       consumed_count: '0, run_last: 1'b1};
        unique case (phase_reg)
            PH_HDR_HI: begin
                len_next   = {s_tdata, len_reg[7:0]};
                cnt_next   = 16'd0;
                crc_next   = CRC_ALL_ONES;
                rcrc_next  = 32'd0;
                phase_next = (len_next == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                res0.payload_byte = s_tdata;
                res0.run_last     = !s_tlast;
                push_n            = 2'd1;
                crc_next          = crc_byte(crc_reg, s_tdata);
                cnt_next          = cnt_inc;
                if (cnt_inc >= len_reg) begin
                    phase_next = PH_CRC0;
                end
            end
            PH_CRC0: begin
                rcrc_next[7:0] = s_tdata;
                phase_next     = PH_CRC1;
            end
            PH_CRC1: begin
                rcrc_next[15:8] = s_tdata;
                phase_next      = PH_CRC2;
            end
            PH_CRC2: begin
                rcrc_next[23:16] = s_tdata;
                phase_next       = PH_CRC3;
            end
            PH_CRC3: begin
                res0.kind           = ((crc_reg ^ CRC_ALL_ONES) == rcrc_full) ? KIND_OK
                                                                               : KIND_BAD;
                res0.consumed_count = {1'b0, len_reg} + FRAME_OVERHEAD;
                push_n              = 2'd1;
                done                = 1'b1;
            end
            default: begin
                len_next   = {8'd0, s_tdata};
                phase_next = PH_HDR_HI;
            end
        endcase
        if (s_tlast && !done) begin
            if (push_n == 2'd0) begin
                res0   = res1;
                push_n = 2'd1;
            end else begin
                push_n = 2'd2;
            end
        end
        if (done || s_tlast) begin
            phase_next = PH_HDR_LO;
            len_next   = 16'd0;
            cnt_next   = 16'd0;
            crc_next   = CRC_ALL_ONES;
            rcrc_next  = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR_LO;
            len_reg   <= 16'd0;
            cnt_reg   <= 16'd0;
            crc_reg   <= CRC_ALL_ONES;
            rcrc_reg  <= 32'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (accept && push_n == 2'd2) begin
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            fill_reg <= fill_reg + (accept ? QCNT_W'(push_n) : '0) - QCNT_W'(pop);
        end
    end

    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {7'd0, q_reg[rd_ptr_reg].consumed_count,
                       q_reg[rd_ptr_reg].payload_byte};
    assign m_tuser  = q_reg[rd_ptr_reg].kind;
    assign m_tlast  = q_reg[rd_ptr_reg].run_last;

    `DFR_ASSERT(a_fill_bound, fill_reg <= QCNT_W'(QDEPTH))
    `DFR_ASSERT(a_last_resets, accept && s_tlast |=> phase_reg == PH_HDR_LO)
    `DFR_ASSERT(a_payload_len, phase_reg == PH_PAYLOAD |-> len_reg != 16'd0 && cnt_reg < len_reg)
    `DFR_ASSERT_RST(a_reset_state, !aresetn |=> phase_reg == PH_HDR_LO && fill_reg == '0)

endmodule

FILE: bench/deframer_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the CRC-32 deframer: watches both stream channels, predicts the
// result beats of every accepted input beat and compares them in order.
// Depends on crcdfr_pkg for the phase, kind and result types.
module deframer_checker
    import crcdfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // buffer_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [7:0] payload_byte, [24:8] consumed_count, rest zero
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,   // run_last
    output int          fail_count,
    output int          pending,
    output int          ok_frames,
    output int          bad_frames,
    output int          cut_frames,
    output int          payload_beats
);

    phase_t      ph;
    logic [15:0] frame_len;
    logic [15:0] byte_cnt;
    logic [31:0] crc_run;
    logic [31:0] crc_rx;
    result_t     deframed_q[$];
    int          errs = 0;
    int          n_ok = 0;
    int          n_bad = 0;
    int          n_cut = 0;
    int          n_payload = 0;

    function automatic logic [31:0] crc32_shift_byte(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ ((r[0] ^ d[k]) ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    task automatic reset_frame();
        ph        = PH_HDR_LO;
        frame_len = '0;
        byte_cnt  = '0;
        crc_run   = CRC_ALL_ONES;
        crc_rx    = '0;
    endtask

    task automatic queue_result(input kind_t k, input logic [7:0] pb,
                                input logic [COUNT_W-1:0] cnt);
        result_t r;
        r.kind           = k;
        r.payload_byte   = pb;
        r.consumed_count = cnt;
        r.run_last       = 1'b0;
        deframed_q = {deframed_q, r};
        unique case (k)
            KIND_PAYLOAD: n_payload++;
            KIND_OK:      n_ok++;
            KIND_BAD:     n_bad++;
            default:      n_cut++;
        endcase
    endtask

    task automatic deframe_byte(input logic [7:0] rx, input logic buf_end);
        int      base;
        logic    closed;
        base   = deframed_q.size();
        closed = 1'b0;
        unique case (ph)
            PH_HDR_HI: begin
                frame_len[15:8] = rx;
                byte_cnt = '0;
                crc_run  = CRC_ALL_ONES;
                crc_rx   = '0;
                ph = (frame_len == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                queue_result(KIND_PAYLOAD, rx, '0);
                crc_run  = crc32_shift_byte(crc_run, rx);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= frame_len) ph = PH_CRC0;
            end
            PH_CRC0, PH_CRC1, PH_CRC2: begin
                crc_rx = crc_rx | ({24'd0, rx} << (8 * (ph - PH_CRC0)));
                ph = phase_t'(ph + 3'd1);
            end
            PH_CRC3: begin
                crc_rx[31:24] = rx;
                queue_result((~crc_run == crc_rx) ? KIND_OK : KIND_BAD, 8'h00,
                             {1'b0, frame_len} + FRAME_OVERHEAD);
                reset_frame();
                closed = 1'b1;
            end
            default: begin
                frame_len = {8'h00, rx};
                ph = PH_HDR_HI;
            end
        endcase
        if (buf_end && !closed) begin
            queue_result(KIND_TRUNC, 8'h00, '0);
            reset_frame();
        end
        if (deframed_q.size() > base) begin
            deframed_q[deframed_q.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (deframed_q.size() == 0) begin
            $error("result beat with nothing expected: kind %0d, tdata %h", m_tuser, m_tdata);
            errs++;
        end else begin
            want = deframed_q.pop_front();
            compare_field("kind", 32'(want.kind), 32'(m_tuser));
            compare_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
            compare_field("consumed_count", 32'(want.consumed_count), 32'(m_tdata[24:8]));
            compare_field("tdata_pad", 32'd0, 32'(m_tdata[31:25]));
            compare_field("run_last", 32'(want.run_last), 32'(m_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_frame();
            deframed_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) deframe_byte(s_tdata, s_tlast);
        end
        fail_count    <= errs;
        pending       <= deframed_q.size();
        ok_frames     <= n_ok;
        bad_frames    <= n_bad;
        cut_frames    <= n_cut;
        payload_beats <= n_payload;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the deframer bench: clock, reset, frame stimulus with random idling and
// back-pressure, watchdog and verdict. Depends on crcdfr_pkg, the deframer and
// deframer_checker.
module tb_top;
    import crcdfr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_BEATS = 1800;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tlast = 1'b0;    // buffer_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] payload_byte, [24:8] consumed_count, rest zero
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        m_tlast;           // run_last

    int fail_count, pending, ok_frames, bad_frames, cut_frames, payload_beats;
    int sent_beats = 0;
    int stall_cycles = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_go = 1'b0;

    crc32_length_prefixed_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    deframer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .ok_frames     (ok_frames),
        .bad_frames    (bad_frames),
        .cut_frames    (cut_frames),
        .payload_beats (payload_beats)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stalls, a stall-free stretch, and one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= rx_idle_en ? ($urandom_range(99) >= 36) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("crc32_length_prefixed_deframer test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic fin);
        while (tx_idle_en && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sent_beats++;
    endtask

    // send one frame; flaw flips a bit after the header, end_at raises tlast on that
    // beat and stops there, fill >= 0 gives a constant payload
    task automatic send_frame(input int len, input bit flaw, input int end_at, input int fill);
        logic [31:0] crc;
        logic [31:0] crc_out;
        logic [7:0]  b;
        int          total;
        int          flip_at;
        total   = len + 6;
        flip_at = flaw ? $urandom_range(total - 1, 2) : -1;
        crc     = CRC_ALL_ONES;
        crc_out = '0;
        for (int i = 0; i < total; i++) begin
            if (i == 0) begin
                b = len[7:0];
            end else if (i == 1) begin
                b = len[15:8];
            end else if (i < len + 2) begin
                b = (fill < 0) ? 8'($urandom) : fill[7:0];
                for (int k = 0; k < 8; k++) begin
                    crc = (crc >> 1) ^ ((crc[0] ^ b[k]) ? CRC_POLY : 32'h0);
                end
                crc_out = ~crc;
            end else begin
                if (len == 0) crc_out = ~crc;
                b = crc_out[8 * (i - len - 2) +: 8];
            end
            if (i == flip_at) b ^= 8'(1 << $urandom_range(7, 0));
            send_beat(b, i == end_at);
            if (i == end_at) break;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int fi;
        int pick;
        int len;
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame(0, 1'b0, -1, 0);
        send_frame(0, 1'b1, -1, 0);
        send_frame(1, 1'b0, 6, 8'hFF);
        send_frame(3, 1'b0, 0, -1);
        send_frame(2, 1'b0, 2, 8'h00);
        send_frame(16'hFFFF, 1'b0, 1, -1);
        drain();

        fi = 0;
        while (sent_beats < RANDOM_BEATS + 25) begin
            if (fi == 20) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (fi == 60) begin
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b1;
            end
            if (fi % 70 == 35) drain();
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 0);
            if (fi == 90) begin
                hold_go = 1'b1;
                send_frame(64, 1'b0, -1, -1);
            end else if (pick < 55) begin
                send_frame(len, 1'b0, ($urandom_range(3) == 0) ? len + 5 : -1, -1);
            end else if (pick < 70) begin
                send_frame(len, 1'b1, -1, -1);
            end else if (pick < 85) begin
                if ($urandom_range(2) == 0) len = $urandom_range(65535, 0);
                send_frame(len, 1'b0, $urandom_range((len < 36) ? len + 4 : 40, 0), -1);
            end else begin
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++) send_beat(8'($urandom), i == n - 1);
            end
            fi++;
        end

        drain();
        repeat (4) @(posedge aclk);

        $display("Sent %0d input beats in %0d random frames plus directed cases.",
                 sent_beats, fi);
        $display("Saw %0d good frames, %0d CRC mismatches, %0d truncations, %0d payload beats.",
                 ok_frames, bad_frames, cut_frames, payload_beats);
        if (fail_count == 0) begin
            $display("crc32_length_prefixed_deframer test passed");
        end else begin
            $display("crc32_length_prefixed_deframer test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/crcdfr_pkg.sv
sv/crc32_length_prefixed_deframer.sv
bench/deframer_checker.sv
bench/tb_top.sv
